[rtl/tpalc_pkg.sv]
// Package: shared types and constants for the transmit peak level control.
package tpalc_pkg;

   localparam int GAIN_BITS = 18;
   localparam int GAIN_FRAC = 16;
   localparam int PRE_BITS  = 16;
   localparam int PRE_FRAC  = 12;
   localparam int CSR_IDX_BITS = 3;

   typedef enum logic [2:0] {
      CSR_PREGAIN      = 3'd0,
      CSR_ATTACK_RAMP  = 3'd1,
      CSR_RELEASE_RAMP = 3'd2,
      CSR_ENV_RAMP     = 3'd3,
      CSR_MAX_GAIN     = 3'd4,
      CSR_MIN_GAIN     = 3'd5,
      CSR_TARGET_LEVEL = 3'd6,
      CSR_AM_MODE      = 3'd7
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE_I,
      ST_PRE_Q,
      ST_ENV,
      ST_LEVEL,
      ST_GAIN,
      ST_OUT_I,
      ST_OUT_Q,
      ST_DONE
   } state_type;

   // Multiplier control between sequencer and serial multiplier.
   typedef struct packed {
      logic start;
      logic busy;
   } mul_ctl_type;

endpackage

[rtl/tpalc_if.sv]
// Interface: valid/ready channel carrying one word of type T.
interface tpalc_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/tx_peak_alc_unit.sv]
// Top level: transmit peak envelope level control with a shared serial multiplier.
//
//  channel | dir | handshake        | word
//  req     | in  | valid/ready      | in_i, in_q, last_in
//  rsp     | out | valid/ready      | out_i, out_q, gain_now, reducing,
//          |     |                  | clipped, block_peak, attack_total, last_out
//  csr     | in  | write enable     | index, data (no read-back)
//
// Every product runs through one bit-serial multiplier: a start strobe, one
// multiplier bit a cycle, then a done strobe. A word needs up to seven
// products in sequence; AM mode drops two products, an envelope jump drops one.
// Synchronous active-high reset restores the configuration, state, envelope,
// gain, peak and count registers to defaults, but not the sample, output and
// flag registers. The result sits in the output register until taken; the
// next word is accepted only after that, so a stalled rsp holds req off.
module tx_peak_alc_unit #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int RAMP_FRAC_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_in_i,
   input  logic signed [SAMPLE_WIDTH-1:0] req_in_q,
   input  logic req_last_in,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_i,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_q,
   output logic [tpalc_pkg::GAIN_BITS-1:0] rsp_gain_now,
   output logic rsp_reducing,
   output logic rsp_clipped,
   output logic [SAMPLE_WIDTH-1:0] rsp_block_peak,
   output logic [31:0] rsp_attack_total,
   output logic rsp_last_out,
   input  logic csr_wr_en,
   input  logic [tpalc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [((RAMP_FRAC_BITS + 1 > SAMPLE_WIDTH + 4) ? RAMP_FRAC_BITS + 1
                                                          : SAMPLE_WIDTH + 4)-1:0] csr_wr_data
);
   localparam int R  = RAMP_FRAC_BITS;
   localparam int S  = SAMPLE_WIDTH;
   localparam int W  = S + 4;                       // wide sample / envelope
   localparam int GB = tpalc_pkg::GAIN_BITS;
   localparam int GF = tpalc_pkg::GAIN_FRAC;
   localparam int MA = W + GF + 2;                  // multiplicand width
   localparam int MB = (R + 1 > GB) ? R + 1 : GB;   // multiplier width
   localparam int PW = MA + MB;

   // Configuration registers.
   logic [tpalc_pkg::PRE_BITS-1:0] pregain_ff;
   logic [R-1:0] attack_ff, env_ramp_ff;
   logic [R:0]   release_ff;
   logic [GB-1:0] max_gain_ff, min_gain_ff;
   logic [W-1:0] target_ff;
   logic am_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pregain_ff  <= 16'd4096;
         attack_ff   <= R'(15242446 >> (24 - R > 0 ? 24 - R : 0));
         release_ff  <= (R+1)'((64'd16777753 << R) >> 24);
         env_ramp_ff <= R'(15242446 >> (24 - R > 0 ? 24 - R : 0));
         max_gain_ff <= GB'(65536);
         min_gain_ff <= GB'(6554);
         target_ff   <= W'(30638);
         am_ff       <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (tpalc_pkg::csr_idx_type'(csr_index))
            tpalc_pkg::CSR_PREGAIN:      pregain_ff  <= csr_wr_data[15:0];
            tpalc_pkg::CSR_ATTACK_RAMP:  attack_ff   <= csr_wr_data[R-1:0];
            tpalc_pkg::CSR_RELEASE_RAMP: release_ff  <= csr_wr_data[R:0];
            tpalc_pkg::CSR_ENV_RAMP:     env_ramp_ff <= csr_wr_data[R-1:0];
            tpalc_pkg::CSR_MAX_GAIN:     max_gain_ff <= csr_wr_data[GB-1:0];
            tpalc_pkg::CSR_MIN_GAIN:     min_gain_ff <= csr_wr_data[GB-1:0];
            tpalc_pkg::CSR_TARGET_LEVEL: target_ff   <= csr_wr_data[W-1:0];
            tpalc_pkg::CSR_AM_MODE:      am_ff       <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // Shared serial multiplier; signed operands go in as magnitudes.
   tpalc_pkg::mul_ctl_type mctl;
   logic [MA-1:0] ma;
   logic [MB-1:0] mb;
   logic          mdone;
   logic [PW-1:0] mprod;

   tpalc_mul #(.A_BITS(MA), .B_BITS(MB)) u_mul (
      .clock(clock), .reset(reset), .start(mctl.start),
      .a(ma), .b(mb), .done(mdone), .prod(mprod)
   );

   tpalc_pkg::state_type st_ff, st_in;
   logic signed [W-1:0] si_ff, si_in, sq_ff, sq_in;
   logic [W-1:0]  env_ff, env_in;
   logic [GB-1:0] gain_ff, gain_in;
   logic [S-1:0]  peak_ff, peak_in;
   logic [31:0]   acnt_ff, acnt_in;
   logic          last_ff, last_in, red_ff, red_in, clip_ff, clip_in;
   logic signed [S-1:0] oi_ff, oi_in, oq_ff, oq_in;
   logic          issued_ff, issued_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Signed product helpers: magnitude of sample, sign reapplied after.
   logic signed [W-1:0] cur_s;
   logic [W-1:0]        cur_mag;
   logic                cur_neg;
   logic signed [PW:0]  sprod;
   logic signed [PW:0]  pre_r, out_r;
   logic signed [W-1:0] pre_sat;
   logic signed [S-1:0] out_sat;
   logic                out_hit;
   logic [PW-1:0]       rel_p;
   logic [PW-1:0]       g_new;
   logic [GB-1:0]       g_clamp;

   always_comb begin
      unique case (st_ff)
         tpalc_pkg::ST_PRE_Q, tpalc_pkg::ST_OUT_Q: cur_s = sq_ff;
         default: cur_s = si_ff;
      endcase
      cur_neg = cur_s[W-1];
      cur_mag = cur_neg ? W'(-cur_s) : W'(cur_s);
      sprod   = cur_neg ? -$signed({1'b0, mprod}) : $signed({1'b0, mprod});
      // round half up, floor shift
      pre_r   = (sprod + (PW+1)'(1 << (tpalc_pkg::PRE_FRAC-1))) >>> tpalc_pkg::PRE_FRAC;
      out_r   = (sprod + (PW+1)'(1 << (GF-1))) >>> GF;
      if (pre_r > (PW+1)'((1 << (W-1)) - 1))      pre_sat = {1'b0, {(W-1){1'b1}}};
      else if (pre_r < -(PW+1)'(1 << (W-1)))     pre_sat = {1'b1, {(W-1){1'b0}}};
      else                                       pre_sat = pre_r[W-1:0];
      out_hit = 1'b1;
      if (out_r > (PW+1)'((1 << (S-1)) - 1))      out_sat = {1'b0, {(S-1){1'b1}}};
      else if (out_r < -(PW+1)'(1 << (S-1)))     out_sat = {1'b1, {(S-1){1'b0}}};
      else begin
         out_sat = out_r[S-1:0];
         out_hit = 1'b0;
      end
      rel_p = mprod + PW'((64'd1 << R) - 1);
      g_new = red_ff ? (mprod >> R) : (rel_p >> R);
      if (g_new > PW'(max_gain_ff)) g_clamp = max_gain_ff;
      else                          g_clamp = g_new[GB-1:0];
      if (g_clamp < min_gain_ff)    g_clamp = min_gain_ff;
   end

   assign req_ready = (st_ff == tpalc_pkg::ST_IDLE) && !rsp_valid_ff;

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         tpalc_pkg::ST_IDLE:
            if (req_valid && req_ready)
               st_in = am_ff ? tpalc_pkg::ST_ENV : tpalc_pkg::ST_PRE_I;
         tpalc_pkg::ST_PRE_I:  if (mdone) st_in = tpalc_pkg::ST_PRE_Q;
         tpalc_pkg::ST_PRE_Q:  if (mdone) st_in = tpalc_pkg::ST_ENV;
         tpalc_pkg::ST_ENV:
            if (cur_mag > env_ff || mdone) st_in = tpalc_pkg::ST_LEVEL;
         tpalc_pkg::ST_LEVEL:  if (mdone) st_in = tpalc_pkg::ST_GAIN;
         tpalc_pkg::ST_GAIN:   if (mdone) st_in = tpalc_pkg::ST_OUT_I;
         tpalc_pkg::ST_OUT_I:  if (mdone) st_in = tpalc_pkg::ST_OUT_Q;
         tpalc_pkg::ST_OUT_Q:  if (mdone) st_in = tpalc_pkg::ST_DONE;
         tpalc_pkg::ST_DONE:   st_in = tpalc_pkg::ST_IDLE;
         default:              st_in = tpalc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and multiplier issue.
   always_comb begin
      si_in = si_ff; sq_in = sq_ff; env_in = env_ff; gain_in = gain_ff;
      peak_in = peak_ff; acnt_in = acnt_ff; last_in = last_ff;
      red_in = red_ff; clip_in = clip_ff; oi_in = oi_ff; oq_in = oq_ff;
      rsp_valid_in = rsp_valid_ff;
      issued_in = issued_ff;
      mctl.start = 1'b0;
      mctl.busy  = 1'b0;
      ma = '0;
      mb = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
         if (last_ff) peak_in = '0;
      end
      unique case (st_ff)
         tpalc_pkg::ST_PRE_I, tpalc_pkg::ST_PRE_Q: begin
            ma = MA'(cur_mag);
            mb = MB'(pregain_ff);
         end
         tpalc_pkg::ST_ENV: begin
            ma = MA'(env_ff);
            mb = MB'(env_ramp_ff);
         end
         tpalc_pkg::ST_LEVEL: begin
            ma = MA'(env_ff);
            mb = MB'(gain_ff);
         end
         tpalc_pkg::ST_GAIN: begin
            ma = MA'(gain_ff);
            mb = red_ff ? MB'(attack_ff) : MB'(release_ff);
         end
         tpalc_pkg::ST_OUT_I, tpalc_pkg::ST_OUT_Q: begin
            ma = MA'(cur_mag);
            mb = MB'(gain_ff);
         end
         default: ;
      endcase
      unique case (st_ff)
         tpalc_pkg::ST_IDLE: begin
            issued_in = 1'b0;
            if (req_valid && req_ready) begin
               si_in = W'(req_in_i);
               sq_in = W'(req_in_q);
               last_in = req_last_in;
               clip_in = 1'b0;
            end
         end
         tpalc_pkg::ST_DONE: begin
            issued_in = 1'b0;
            rsp_valid_in = 1'b1;
            if (W'(oi_ff[S-1] ? -W'(oi_ff) : W'(oi_ff)) > W'(peak_ff))
               peak_in = oi_ff[S-1] ? S'(-oi_ff) : S'(oi_ff);
         end
         default: begin
            mctl.busy = 1'b1;
            if (st_ff == tpalc_pkg::ST_ENV && cur_mag > env_ff) begin
               env_in = cur_mag;
               issued_in = 1'b0;
            end else if (!issued_ff) begin
               mctl.start = 1'b1;
               issued_in = 1'b1;
            end else if (mdone) begin
               issued_in = 1'b0;
               unique case (st_ff)
                  tpalc_pkg::ST_PRE_I: si_in = pre_sat;
                  tpalc_pkg::ST_PRE_Q: sq_in = pre_sat;
                  tpalc_pkg::ST_ENV:   env_in = W'(mprod >> R);
                  tpalc_pkg::ST_LEVEL: begin
                     red_in = mprod >= (PW'(target_ff) << GF);
                     if (mprod >= (PW'(target_ff) << GF)) acnt_in = acnt_ff + 32'd1;
                  end
                  tpalc_pkg::ST_GAIN:  gain_in = g_clamp;
                  tpalc_pkg::ST_OUT_I: begin
                     oi_in = out_sat;
                     clip_in = clip_ff | out_hit;
                  end
                  tpalc_pkg::ST_OUT_Q: begin
                     oq_in = out_sat;
                     clip_in = clip_ff | out_hit;
                  end
                  default: ;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      si_ff <= si_in; sq_ff <= sq_in; oi_ff <= oi_in; oq_ff <= oq_in;
      last_ff <= last_in; clip_ff <= clip_in; red_ff <= red_in;
      if (reset) begin
         st_ff        <= tpalc_pkg::ST_IDLE;
         env_ff       <= W'(1 << (S-1));
         gain_ff      <= GB'(1 << GF);
         peak_ff      <= '0;
         acnt_ff      <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         env_ff       <= env_in;
         gain_ff      <= gain_in;
         peak_ff      <= peak_in;
         acnt_ff      <= acnt_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_i        = oi_ff;
   assign rsp_out_q        = oq_ff;
   assign rsp_gain_now     = gain_ff;
   assign rsp_reducing     = red_ff;
   assign rsp_clipped      = clip_ff;
   assign rsp_block_peak   = peak_ff;
   assign rsp_attack_total = acnt_ff;
   assign rsp_last_out     = last_ff;

   // Hold off new words while a result waits.
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("word accepted while result pending");
   // Multiplier starts only in a working state.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      mctl.start |-> mctl.busy) else $error("multiplier start outside work");
   // Gain lies in the clamp window whenever a result is posted, if min does not exceed max.
   a_gain_clamp: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && min_gain_ff <= max_gain_ff) |->
      (gain_ff <= max_gain_ff && gain_ff >= min_gain_ff)) else $error("gain out of range");
endmodule

[rtl/tpalc_mul.sv]
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module tpalc_mul #(
   parameter int A_BITS = 32,
   parameter int B_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [A_BITS-1:0]        a,
   input  logic [B_BITS-1:0]        b,
   output logic                     done,
   output logic [A_BITS+B_BITS-1:0] prod
);
   localparam int CNT_BITS = $clog2(B_BITS + 1);
   logic [A_BITS+B_BITS-1:0] acc_ff, acc_in;
   logic [B_BITS-1:0]        b_ff, b_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     run_ff, run_in, done_ff, done_in;

   // Shift right accumulation: add a at the top, shift one place per bit.
   always_comb begin
      acc_in  = acc_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         b_in   = b;
         cnt_in = CNT_BITS'(B_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = {1'b0, acc_ff[A_BITS+B_BITS-1:1]}
                  + ({(A_BITS+B_BITS){b_ff[0]}} & {1'b0, a, {(B_BITS-1){1'b0}}});
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

[sim/tx_peak_alc_unit_tb.sv]
// Testbench for tx_peak_alc_unit: directed passes, then random register sets and samples, each word checked against a cycle-free predictor.
`timescale 1ns / 100ps

module tx_peak_alc_unit_tb;

   localparam int SW = 16;
   localparam int RB = 24;
   localparam int WB = SW + 4;
   // The serial multiplier works through each word's products in sequence; give it ample margin.
   localparam int DRAIN_CYCLES = 400;
   localparam int STALL_LIMIT  = 20000;

   typedef struct packed {
      logic signed [SW-1:0] in_i;
      logic signed [SW-1:0] in_q;
      logic                 last_in;
   } sample_word_type;

   typedef struct packed {
      logic signed [SW-1:0]               out_i;
      logic signed [SW-1:0]               out_q;
      logic [tpalc_pkg::GAIN_BITS-1:0]    gain_now;
      logic                               reducing;
      logic                               clipped;
      logic [SW-1:0]                      block_peak;
      logic [31:0]                        attack_total;
      logic                               last_out;
   } level_word_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [tpalc_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [RB:0] csr_wr_data;

   tpalc_if #(.T(sample_word_type)) req_ch ();
   tpalc_if #(.T(level_word_type))  rsp_ch ();

   tx_peak_alc_unit #(.SAMPLE_WIDTH(SW), .RAMP_FRAC_BITS(RB)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_in_i         (req_ch.data.in_i),
      .req_in_q         (req_ch.data.in_q),
      .req_last_in      (req_ch.data.last_in),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_out_i        (rsp_ch.data.out_i),
      .rsp_out_q        (rsp_ch.data.out_q),
      .rsp_gain_now     (rsp_ch.data.gain_now),
      .rsp_reducing     (rsp_ch.data.reducing),
      .rsp_clipped      (rsp_ch.data.clipped),
      .rsp_block_peak   (rsp_ch.data.block_peak),
      .rsp_attack_total (rsp_ch.data.attack_total),
      .rsp_last_out     (rsp_ch.data.last_out),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   // Predictor copy of the register file.
   longint r_pregain, r_attack, r_release, r_env_ramp;
   longint r_max_gain, r_min_gain, r_target, r_am;
   // Predictor copy of the running state.
   longint env_level, cur_gain, blk_peak;
   logic [31:0] attack_cnt;

   level_word_type expected_words[$];
   int err_count;
   int quiet_cycles;
   bit no_gaps;   // when set, neither side inserts gaps

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drive every input to a known value from time zero.
   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wr_data   = '0;
      req_ch.valid  = 1'b0;
      req_ch.data   = '0;
      rsp_ch.ready  = 1'b0;
   end

   // Round half up: floor((v + 2^(sh-1)) / 2^sh); arithmetic shift gives the floor.
   function automatic longint round_up_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp_signed(longint v, int w, inout bit hit);
      longint hi, lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -(longint'(1) << (w - 1));
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic void reset_model();
      r_pregain  = 4096;
      r_attack   = 15242446;
      r_release  = 16777753;
      r_env_ramp = 15242446;
      r_max_gain = 65536;
      r_min_gain = 6554;
      r_target   = 30638;
      r_am       = 0;
      env_level  = longint'(1) << (SW - 1);
      cur_gain   = longint'(1) << tpalc_pkg::GAIN_FRAC;
      blk_peak   = 0;
      attack_cnt = '0;
   endfunction

   // Advance the level loop by one sample and return the word it must produce.
   function automatic level_word_type level_step(sample_word_type s);
      level_word_type r;
      longint si, sq, mag, g, oi, oq;
      bit spare, clip, cut;
      spare = 1'b0;
      clip  = 1'b0;
      si = longint'(s.in_i);
      sq = longint'(s.in_q);
      if (r_am == 0) begin
         si = clamp_signed(round_up_shift(si * r_pregain, tpalc_pkg::PRE_FRAC), WB, spare);
         sq = clamp_signed(round_up_shift(sq * r_pregain, tpalc_pkg::PRE_FRAC), WB, spare);
      end
      mag = (si < 0) ? -si : si;
      if (mag > env_level) env_level = mag;
      else env_level = (env_level * r_env_ramp) >> RB;
      g = cur_gain;
      cut = (env_level * g) >= (r_target << tpalc_pkg::GAIN_FRAC);
      if (cut) begin
         attack_cnt = attack_cnt + 32'd1;
         g = (g * r_attack) >> RB;
      end else begin
         g = (g * r_release + ((longint'(1) << RB) - 1)) >> RB;
      end
      if (g > r_max_gain) g = r_max_gain;
      if (g < r_min_gain) g = r_min_gain;
      cur_gain = g;
      oi = clamp_signed(round_up_shift(si * g, tpalc_pkg::GAIN_FRAC), SW, clip);
      oq = clamp_signed(round_up_shift(sq * g, tpalc_pkg::GAIN_FRAC), SW, clip);
      mag = (oi < 0) ? -oi : oi;
      if (mag > blk_peak) blk_peak = mag;
      r.out_i        = oi[SW-1:0];
      r.out_q        = oq[SW-1:0];
      r.gain_now     = g[tpalc_pkg::GAIN_BITS-1:0];
      r.reducing     = cut;
      r.clipped      = clip;
      r.block_peak   = blk_peak[SW-1:0];
      r.attack_total = attack_cnt;
      r.last_out     = s.last_in;
      if (s.last_in) blk_peak = 0;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      err_count++;
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
   endtask

   // Pick a gap length: mostly none or short, a few long.
   function automatic int pick_gap();
      int roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // Hold the csr strobe; the caller drops it with end_csr_writes.
   task automatic write_csr(tpalc_pkg::csr_idx_type idx, longint value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value[RB:0];
      case (idx)
         tpalc_pkg::CSR_PREGAIN:      r_pregain  = value & 64'hFFFF;
         tpalc_pkg::CSR_ATTACK_RAMP:  r_attack   = value & ((longint'(1) << RB) - 1);
         tpalc_pkg::CSR_RELEASE_RAMP: r_release  = value & ((longint'(1) << (RB + 1)) - 1);
         tpalc_pkg::CSR_ENV_RAMP:     r_env_ramp = value & ((longint'(1) << RB) - 1);
         tpalc_pkg::CSR_MAX_GAIN:
            r_max_gain = value & ((longint'(1) << tpalc_pkg::GAIN_BITS) - 1);
         tpalc_pkg::CSR_MIN_GAIN:
            r_min_gain = value & ((longint'(1) << tpalc_pkg::GAIN_BITS) - 1);
         tpalc_pkg::CSR_TARGET_LEVEL: r_target   = value & ((longint'(1) << WB) - 1);
         tpalc_pkg::CSR_AM_MODE:      r_am       = value & 1;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic end_csr_writes();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every expected word has come back, then let the datapath settle.
   task automatic drain();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Present one sample, hold until taken, then maybe drop valid for a gap.
   task automatic send_sample(logic signed [SW-1:0] i_val, logic signed [SW-1:0] q_val,
                              logic last);
      sample_word_type w;
      int gap;
      w.in_i    = i_val;
      w.in_q    = q_val;
      w.last_in = last;
      req_ch.valid <= 1'b1;
      req_ch.data  <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_words.push_back(level_step(w));
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sample with moderate amplitude most often, else any value, full scale or small.
   function automatic logic signed [SW-1:0] rand_sample();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 2) return $signed(16'($urandom_range(0, 65535)));
      if (roll < 4) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      if (roll < 6) return $signed(16'($urandom_range(0, 255))) - 16'sd128;
      return $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
   endfunction

   // Send a run of blocks, each closed by a last flag.
   task automatic send_blocks(int count);
      int left;
      int run;
      left = count;
      while (left > 0) begin
         run = $urandom_range(1, 24);
         if (run > left) run = left;
         for (int k = 0; k < run; k++)
            send_sample(rand_sample(), rand_sample(), (k == run - 1));
         left -= run;
      end
   endtask

   // Defaults after reset: full-scale, zero and small samples, block ends.
   task automatic test_defaults();
      no_gaps = 1'b1;
      send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 16'sh8000, 1'b0);
      send_sample(16'sh0000, 16'sh0000, 1'b1);
      send_sample(16'sh8000, 16'sh7FFF, 1'b0);
      send_sample(16'sh0001, 16'shFFFF, 1'b0);
      send_sample(16'shAAAA, 16'sh5555, 1'b1);
      no_gaps = 1'b0;
      for (int k = 0; k < 6; k++) send_sample(16'sh0010, 16'shFFF0, k == 5);
      stop_sending();
      drain();
   endtask

   // Register extremes: max pregain, AM mode, zero target, min above max,
   // release below one, release at its maximum.
   task automatic test_register_extremes();
      write_csr(tpalc_pkg::CSR_PREGAIN, 65535);
      write_csr(tpalc_pkg::CSR_TARGET_LEVEL, 0);
      write_csr(tpalc_pkg::CSR_ATTACK_RAMP, 0);
      end_csr_writes();
      send_sample(16'sh7FFF, 16'sh8000, 1'b0);
      send_sample(16'sh8000, 16'sh7FFF, 1'b1);
      stop_sending();
      drain();
      write_csr(tpalc_pkg::CSR_PREGAIN, 0);
      write_csr(tpalc_pkg::CSR_TARGET_LEVEL, 1048575);
      write_csr(tpalc_pkg::CSR_RELEASE_RAMP, 33554431);
      write_csr(tpalc_pkg::CSR_MAX_GAIN, 262143);
      write_csr(tpalc_pkg::CSR_MIN_GAIN, 0);
      write_csr(tpalc_pkg::CSR_ENV_RAMP, 16777215);
      end_csr_writes();
      send_sample(16'sh7FFF, 16'sh8000, 1'b0);
      send_sample(16'sh1234, 16'sh4321, 1'b1);
      stop_sending();
      drain();
      write_csr(tpalc_pkg::CSR_AM_MODE, 1);
      write_csr(tpalc_pkg::CSR_PREGAIN, 4096);
      write_csr(tpalc_pkg::CSR_MIN_GAIN, 262143);
      write_csr(tpalc_pkg::CSR_MAX_GAIN, 0);
      write_csr(tpalc_pkg::CSR_ENV_RAMP, 0);
      end_csr_writes();
      send_sample(16'sh7FFF, 16'sh8000, 1'b0);
      send_sample(16'sh4000, 16'shC000, 1'b1);
      stop_sending();
      drain();
      write_csr(tpalc_pkg::CSR_AM_MODE, 0);
      write_csr(tpalc_pkg::CSR_MIN_GAIN, 6554);
      write_csr(tpalc_pkg::CSR_MAX_GAIN, 131072);
      write_csr(tpalc_pkg::CSR_RELEASE_RAMP, 1000000);
      write_csr(tpalc_pkg::CSR_ATTACK_RAMP, 16777215);
      write_csr(tpalc_pkg::CSR_TARGET_LEVEL, 30638);
      end_csr_writes();
      for (int k = 0; k < 5; k++) send_sample(16'sh0100, 16'shFF00, k == 4);
      stop_sending();
      drain();
   endtask

   // Random register set per phase, mostly realistic values near unity.
   task automatic test_random_phases(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         write_csr(tpalc_pkg::CSR_PREGAIN,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(2048, 12288));
         write_csr(tpalc_pkg::CSR_ATTACK_RAMP,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215)
                                               : $urandom_range(14000000, 16777215));
         write_csr(tpalc_pkg::CSR_RELEASE_RAMP,
                   $urandom_range(16777216, ($urandom_range(0, 3) == 0) ?
                                  33554431 : 17000000));
         write_csr(tpalc_pkg::CSR_ENV_RAMP,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215)
                                               : $urandom_range(14000000, 16777215));
         write_csr(tpalc_pkg::CSR_MAX_GAIN, $urandom_range(40000, 262143));
         write_csr(tpalc_pkg::CSR_MIN_GAIN, $urandom_range(0, 30000));
         write_csr(tpalc_pkg::CSR_TARGET_LEVEL,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1048575)
                                               : $urandom_range(4000, 60000));
         write_csr(tpalc_pkg::CSR_AM_MODE, $urandom_range(0, 1));
         end_csr_writes();
         no_gaps = ($urandom_range(0, 3) == 0);
         send_blocks(per_phase);
         stop_sending();
         no_gaps = 1'b0;
         drain();
      end
   endtask

   // Response side: random stalls, same gap profile as the sender.
   initial begin
      int stall;
      stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   // Compare each taken word with the oldest expectation.
   always @(posedge clock) begin
      level_word_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected rsp word", 1, 0);
         end else begin
            want = expected_words.pop_front();
            if (got.out_i !== want.out_i) report_mismatch("out_i", got.out_i, want.out_i);
            if (got.out_q !== want.out_q) report_mismatch("out_q", got.out_q, want.out_q);
            if (got.gain_now !== want.gain_now)
               report_mismatch("gain_now", got.gain_now, want.gain_now);
            if (got.reducing !== want.reducing)
               report_mismatch("reducing", got.reducing, want.reducing);
            if (got.clipped !== want.clipped)
               report_mismatch("clipped", got.clipped, want.clipped);
            if (got.block_peak !== want.block_peak)
               report_mismatch("block_peak", got.block_peak, want.block_peak);
            if (got.attack_total !== want.attack_total)
               report_mismatch("attack_total", got.attack_total, want.attack_total);
            if (got.last_out !== want.last_out)
               report_mismatch("last_out", got.last_out, want.last_out);
         end
      end
   end

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL tx_peak_alc_unit");
         $finish;
      end
   end

   initial begin
      err_count    = 0;
      quiet_cycles = 0;
      no_gaps      = 1'b0;
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_register_extremes();
      test_random_phases(8, 105);
      if (err_count == 0)
         $display("PASS tx_peak_alc_unit");
      else
         $display("FAIL tx_peak_alc_unit");
      $finish;
   end

endmodule

[sim.f]
rtl/tpalc_pkg.sv
rtl/tpalc_if.sv
rtl/tpalc_mul.sv
rtl/tx_peak_alc_unit.sv
sim/tx_peak_alc_unit_tb.sv
